// ----- hdl/awt_pkg.sv -----
// Shared types, constants and the quota function for the activation window throttle policy.
package awt_pkg;

	localparam int NUM_CORES_DEF  = 8;
	localparam int COUNT_BITS_DEF = 16;
	localparam int CFG_IDX_W      = 8;
	localparam int CFG_DATA_W     = 32;
	localparam int WINDOW_W       = 31;
	localparam int QUOTA_W        = 8;
	localparam int THRESH_W       = 16;
	localparam int CORE_ID_W      = 8;
	localparam int OUT_CORE_W     = 3;
	localparam int MASK_W         = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLED        = 8'd0,
		REG_WINDOW_CLOCKS  = 8'd1,
		REG_QUOTA_MIN      = 8'd2,
		REG_QUOTA_MAX      = 8'd3,
		REG_RULE_CONDITION = 8'd4,
		REG_RULE_THRESHOLD = 8'd5,
		REG_ACTION_KIND    = 8'd6,
		REG_ACTION_AMOUNT  = 8'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_GE = 2'd0,
		OP_GT = 2'd1,
		OP_LE = 2'd2,
		OP_LT = 2'd3
	} rule_op_t;

	typedef enum logic {
		ACT_SET      = 1'b0,
		ACT_DECREASE = 1'b1
	} action_kind_t;

	typedef enum logic {
		ST_EMPTY,
		ST_FULL
	} awt_state_t;

	typedef struct packed {
		logic                 request_valid;
		logic                 is_row_activation;
		logic [CORE_ID_W-1:0] source_core;
	} awt_req_t;

	typedef struct packed {
		logic                  throttle_valid;
		logic [OUT_CORE_W-1:0] throttle_core;
		logic [QUOTA_W-1:0]    throttle_limit;
		logic                  window_closed;
		logic [MASK_W-1:0]     released_mask;
		logic                  invalid_source;
	} awt_rsp_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] value;
	} awt_cfg_t;

	typedef struct packed {
		logic step;
	} awt_cmd_t;

	function automatic logic [QUOTA_W-1:0] new_quota(
		input logic               kind,
		input logic [QUOTA_W-1:0] lo,
		input logic [QUOTA_W-1:0] hi,
		input logic [QUOTA_W-1:0] amt
	);
		logic signed [QUOTA_W+1:0] v;
		logic signed [QUOTA_W+1:0] lo_s;
		lo_s = signed'({2'b00, lo});
		if (kind == ACT_SET) begin
			v = (amt < hi) ? signed'({2'b00, amt}) : signed'({2'b00, hi});
		end else begin
			v = signed'({2'b00, hi}) + signed'((QUOTA_W+2)'(1)) - signed'({2'b00, amt});
		end
		if (v < lo_s) begin
			v = lo_s;
		end
		if (v > signed'((QUOTA_W+2)'(255))) begin
			v = signed'((QUOTA_W+2)'(255));
		end
		return v[QUOTA_W-1:0];
	endfunction

endpackage

// ----- hdl/awt_chan_if.sv -----
// Valid/ready channel interface carrying one payload struct.
interface awt_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/awt_ctrl.sv -----
// Handshake controller: tracks the output register and issues the step command.
module awt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output awt_pkg::awt_cmd_t cmd
);
	import awt_pkg::*;

	awt_state_t state_q;
	awt_state_t state_next;
	logic       accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_EMPTY: begin
				if (accept) begin
					state_next = ST_FULL;
				end
			end
			ST_FULL: begin
				if (accept) begin
					state_next = ST_FULL;
				end else if (out_ready) begin
					state_next = ST_EMPTY;
				end
			end
			default: state_next = ST_EMPTY;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_EMPTY: begin
				in_ready  = 1'b1;
				out_valid = 1'b0;
			end
			ST_FULL: begin
				in_ready  = out_ready;
				out_valid = 1'b1;
			end
			default: begin
				in_ready  = 1'b0;
				out_valid = 1'b0;
			end
		endcase
		cmd.step = accept;
	end

endmodule

// ----- hdl/awt_dpath.sv -----
// Datapath: registers, window counters, rule check, quota and result register.
module awt_dpath #(
	parameter int NUM_CORES  = awt_pkg::NUM_CORES_DEF,
	parameter int COUNT_BITS = awt_pkg::COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  awt_pkg::awt_cmd_t cmd,
	input  awt_pkg::awt_req_t req_data,
	input  logic              cfg_we,
	input  awt_pkg::awt_cfg_t cfg_data,
	output awt_pkg::awt_rsp_t rsp_data
);
	import awt_pkg::*;

	localparam int CORE_BITS = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
	localparam int CMP_W     = (COUNT_BITS > THRESH_W) ? COUNT_BITS : THRESH_W;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic                  enabled_q;
	logic [WINDOW_W-1:0]   window_clocks_q;
	logic [QUOTA_W-1:0]    quota_min_q;
	logic [QUOTA_W-1:0]    quota_max_q;
	logic [2:0]            rule_condition_q;
	logic [THRESH_W-1:0]   rule_threshold_q;
	logic                  action_kind_q;
	logic [QUOTA_W-1:0]    action_amount_q;

	logic [WINDOW_W-1:0]   tick_phase_q;
	logic [COUNT_BITS-1:0] cur_q  [NUM_CORES];
	logic [COUNT_BITS-1:0] prev_q [NUM_CORES];
	logic [NUM_CORES-1:0]  thr_q;
	awt_rsp_t              rsp_q;

	logic                  act;
	logic                  src_ok;
	logic [CORE_BITS-1:0]  idx;
	logic [WINDOW_W-1:0]   phase_inc;
	logic [WINDOW_W-1:0]   period;
	logic                  close;
	logic [COUNT_BITS-1:0] cur_sel;
	logic [COUNT_BITS-1:0] cnt_new;
	logic [COUNT_BITS-1:0] feature;
	logic [CMP_W-1:0]      feat_ext;
	logic [CMP_W-1:0]      thr_ext;
	logic                  hit;
	logic                  do_count;
	logic                  do_throttle;
	logic                  do_close;
	logic [NUM_CORES-1:0]  thr_after;
	logic [COUNT_BITS-1:0] cur_after [NUM_CORES];
	logic [MASK_W-1:0]     mask;
	awt_rsp_t              rsp_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q        <= 1'b0;
			window_clocks_q  <= WINDOW_W'(1);
			quota_min_q      <= QUOTA_W'(1);
			quota_max_q      <= QUOTA_W'(1);
			rule_condition_q <= '0;
			rule_threshold_q <= '0;
			action_kind_q    <= 1'b0;
			action_amount_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_data.index)
				REG_ENABLED:        enabled_q        <= cfg_data.value[0];
				REG_WINDOW_CLOCKS:  window_clocks_q  <= cfg_data.value[WINDOW_W-1:0];
				REG_QUOTA_MIN:      quota_min_q      <= cfg_data.value[QUOTA_W-1:0];
				REG_QUOTA_MAX:      quota_max_q      <= cfg_data.value[QUOTA_W-1:0];
				REG_RULE_CONDITION: rule_condition_q <= cfg_data.value[2:0];
				REG_RULE_THRESHOLD: rule_threshold_q <= cfg_data.value[THRESH_W-1:0];
				REG_ACTION_KIND:    action_kind_q    <= cfg_data.value[0];
				REG_ACTION_AMOUNT:  action_amount_q  <= cfg_data.value[QUOTA_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		act       = req_data.request_valid && req_data.is_row_activation;
		src_ok    = req_data.source_core < CORE_ID_W'(NUM_CORES);
		idx       = req_data.source_core[CORE_BITS-1:0];
		phase_inc = tick_phase_q + WINDOW_W'(1);
		period    = (window_clocks_q == '0) ? WINDOW_W'(1) : window_clocks_q;
		close     = phase_inc >= period;

		cur_sel  = cur_q[idx];
		cnt_new  = (cur_sel == COUNT_MAX) ? cur_sel : cur_sel + COUNT_BITS'(1);
		feature  = rule_condition_q[2] ? prev_q[idx] : cnt_new;
		feat_ext = CMP_W'(feature);
		thr_ext  = CMP_W'(rule_threshold_q);
		unique case (rule_op_t'(rule_condition_q[1:0]))
			OP_GE:   hit = feat_ext >= thr_ext;
			OP_GT:   hit = feat_ext > thr_ext;
			OP_LE:   hit = feat_ext <= thr_ext;
			OP_LT:   hit = feat_ext < thr_ext;
			default: hit = 1'b0;
		endcase

		do_count    = enabled_q && act && src_ok;
		do_throttle = do_count && hit && !thr_q[idx];
		do_close    = enabled_q && close;

		mask = '0;
		for (int i = 0; i < NUM_CORES; i++) begin
			thr_after[i] = thr_q[i] || (do_throttle && (idx == CORE_BITS'(i)));
			cur_after[i] = (do_count && (idx == CORE_BITS'(i))) ? cnt_new : cur_q[i];
			mask[i]      = do_close && thr_after[i];
		end

		rsp_next.throttle_valid = do_throttle;
		rsp_next.throttle_core  = do_throttle ? req_data.source_core[OUT_CORE_W-1:0] : '0;
		rsp_next.throttle_limit = do_throttle ?
			new_quota(action_kind_q, quota_min_q, quota_max_q, action_amount_q) : '0;
		rsp_next.window_closed  = do_close;
		rsp_next.released_mask  = mask;
		rsp_next.invalid_source = enabled_q && act && !src_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_phase_q <= '0;
			thr_q        <= '0;
			for (int i = 0; i < NUM_CORES; i++) begin
				cur_q[i]  <= '0;
				prev_q[i] <= '0;
			end
		end else if (cmd.step) begin
			tick_phase_q <= close ? '0 : phase_inc;
			for (int i = 0; i < NUM_CORES; i++) begin
				if (do_close) begin
					prev_q[i] <= cur_after[i];
					cur_q[i]  <= '0;
					thr_q[i]  <= 1'b0;
				end else begin
					cur_q[i]  <= cur_after[i];
					thr_q[i]  <= thr_after[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_data = rsp_q;

endmodule

// ----- hdl/activation_window_throttle_policy.sv -----
// Top level of the activation window throttle policy.
//
// Channels: req (sink) takes one controller tick per transaction, carrying
// request_valid, is_row_activation and source_core. rsp (source) returns one
// result transaction per tick: throttle event, window close and release mask,
// and the invalid source flag. cfg (sink) writes register index/value; it is
// always ready; the user must write it only while the block is idle, which the block does not enforce.
// The result of a tick is in the output register in the cycle after the
// tick is taken. Throughput: one transaction per cycle while the receiver takes
// results, set by the single output register, which may be refilled in the cycle it is drained.
// Reset clears configuration to defaults, the tick phase, all window counts
// and all throttle marks; no result is pending after reset.
// When the receiver stalls, the result holds and req.ready drops until the
// pending result is taken.
module activation_window_throttle_policy #(
	parameter int NUM_CORES  = awt_pkg::NUM_CORES_DEF,
	parameter int COUNT_BITS = awt_pkg::COUNT_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	awt_chan_if.sink   req,
	awt_chan_if.source rsp,
	awt_chan_if.sink   cfg
);
	import awt_pkg::*;

	awt_cmd_t cmd;
	awt_req_t req_data;
	awt_cfg_t cfg_data;
	awt_rsp_t rsp_data;

	assign req_data  = req.data;
	assign cfg_data  = cfg.data;
	assign cfg.ready = 1'b1;
	assign rsp.data  = rsp_data;

	awt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	awt_dpath #(
		.NUM_CORES  (NUM_CORES),
		.COUNT_BITS (COUNT_BITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req_data (req_data),
		.cfg_we   (cfg.valid),
		.cfg_data (cfg_data),
		.rsp_data (rsp_data)
	);

endmodule

// ----- hdl/awt_checker.sv -----
// Port-level checks for the activation window throttle policy, bound to the top level.
module awt_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input awt_pkg::awt_rsp_t rsp_data
);
	import awt_pkg::*;

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_data))
		else $error("result changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.throttle_valid |->
			rsp_data.throttle_core == '0 && rsp_data.throttle_limit == '0)
		else $error("throttle fields set without a throttle event");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.window_closed |-> rsp_data.released_mask == '0)
		else $error("cores released without a window close");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.invalid_source |-> !rsp_data.throttle_valid)
		else $error("invalid source produced a throttle event");

endmodule

bind activation_window_throttle_policy awt_checker u_awt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

// ----- dv/awt_policy_checker.sv -----
// Checker that predicts and compares every result transaction of the throttle policy.
module awt_policy_checker #(
	parameter int NUM_CORES  = awt_pkg::NUM_CORES_DEF,
	parameter int COUNT_BITS = awt_pkg::COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_ready,
	input  awt_pkg::awt_req_t req_data,
	input  logic              rsp_valid,
	input  logic              rsp_ready,
	input  awt_pkg::awt_rsp_t rsp_data,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  awt_pkg::awt_cfg_t cfg_data,
	output int                outstanding,
	output int                mismatches
);
	import awt_pkg::*;

	logic                  policy_on;
	logic [WINDOW_W-1:0]   window_len;
	logic [QUOTA_W-1:0]    quota_floor;
	logic [QUOTA_W-1:0]    quota_ceil;
	logic [2:0]            rule_cond;
	logic [THRESH_W-1:0]   rule_thr;
	action_kind_t          act_kind;
	logic [QUOTA_W-1:0]    act_amt;

	logic [WINDOW_W-1:0]   tick_count;
	logic [COUNT_BITS-1:0] live_count [NUM_CORES];
	logic [COUNT_BITS-1:0] last_count [NUM_CORES];
	logic [NUM_CORES-1:0]  held;

	awt_rsp_t              pending_results [$];
	awt_rsp_t              want;

	function automatic void apply_reg(input awt_cfg_t w);
		case (cfg_reg_t'(w.index))
			REG_ENABLED:        policy_on   = w.value[0];
			REG_WINDOW_CLOCKS:  window_len  = w.value[WINDOW_W-1:0];
			REG_QUOTA_MIN:      quota_floor = w.value[QUOTA_W-1:0];
			REG_QUOTA_MAX:      quota_ceil  = w.value[QUOTA_W-1:0];
			REG_RULE_CONDITION: rule_cond   = w.value[2:0];
			REG_RULE_THRESHOLD: rule_thr    = w.value[THRESH_W-1:0];
			REG_ACTION_KIND:    act_kind    = action_kind_t'(w.value[0]);
			REG_ACTION_AMOUNT:  act_amt     = w.value[QUOTA_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic logic rule_met(input logic [COUNT_BITS-1:0] n);
		case (rule_op_t'(rule_cond[1:0]))
			OP_GE:   return n >= rule_thr;
			OP_GT:   return n > rule_thr;
			OP_LE:   return n <= rule_thr;
			default: return n < rule_thr;
		endcase
	endfunction

	function automatic logic [QUOTA_W-1:0] throttled_quota();
		int q;
		if (act_kind == ACT_SET) begin
			q = (act_amt < quota_ceil) ? int'(act_amt) : int'(quota_ceil);
		end else begin
			q = int'(quota_ceil) + 1 - int'(act_amt);
		end
		if (q < int'(quota_floor)) begin
			q = int'(quota_floor);
		end
		if (q > 255) begin
			q = 255;
		end
		return QUOTA_W'(q);
	endfunction

	function automatic awt_rsp_t next_tick_result(input awt_req_t t);
		awt_rsp_t              r;
		logic                  act;
		logic                  close;
		logic [WINDOW_W-1:0]   span;
		logic [COUNT_BITS-1:0] seen;
		int                    c;
		r = '0;
		act = t.request_valid && t.is_row_activation;
		span = (window_len == '0) ? WINDOW_W'(1) : window_len;
		tick_count = tick_count + 1'b1;
		close = tick_count >= span;
		if (close) begin
			tick_count = '0;
		end
		if (policy_on) begin
			c = int'(t.source_core);
			if (act && c >= NUM_CORES) begin
				r.invalid_source = 1'b1;
			end else if (act) begin
				if (live_count[c] != '1) begin
					live_count[c] = live_count[c] + 1'b1;
				end
				seen = rule_cond[2] ? last_count[c] : live_count[c];
				if (rule_met(seen) && !held[c]) begin
					held[c] = 1'b1;
					r.throttle_valid = 1'b1;
					r.throttle_core = OUT_CORE_W'(c);
					r.throttle_limit = throttled_quota();
				end
			end
			if (close) begin
				r.window_closed = 1'b1;
				r.released_mask = MASK_W'(held);
				held = '0;
				for (int i = 0; i < NUM_CORES; i++) begin
					last_count[i] = live_count[i];
					live_count[i] = '0;
				end
			end
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input int got, input int wanted);
		if (got != wanted) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: %s expected %0d, got %0d", $time, name, wanted, got);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_on = 1'b0;
			window_len = WINDOW_W'(1);
			quota_floor = QUOTA_W'(1);
			quota_ceil = QUOTA_W'(1);
			rule_cond = '0;
			rule_thr = '0;
			act_kind = ACT_SET;
			act_amt = '0;
			tick_count = '0;
			held = '0;
			for (int i = 0; i < NUM_CORES; i++) begin
				live_count[i] = '0;
				last_count[i] = '0;
			end
			pending_results.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				apply_reg(cfg_data);
			end
			if (rsp_valid && rsp_ready) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: result transaction with none expected", $time);
					end
				end else begin
					want = pending_results.pop_front();
					check_field("throttle_valid", int'(rsp_data.throttle_valid),
						int'(want.throttle_valid));
					check_field("throttle_core", int'(rsp_data.throttle_core),
						int'(want.throttle_core));
					check_field("throttle_limit", int'(rsp_data.throttle_limit),
						int'(want.throttle_limit));
					check_field("window_closed", int'(rsp_data.window_closed),
						int'(want.window_closed));
					check_field("released_mask", int'(rsp_data.released_mask),
						int'(want.released_mask));
					check_field("invalid_source", int'(rsp_data.invalid_source),
						int'(want.invalid_source));
				end
			end
			if (req_valid && req_ready) begin
				pending_results.insert(pending_results.size(), next_tick_result(req_data));
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

// ----- dv/testbench.sv -----
// Top-level testbench: stimulus, receiver stalls and verdict for the throttle policy.
module testbench;
	import awt_pkg::*;

	localparam int NUM_CORES    = NUM_CORES_DEF;
	localparam int RANDOM_TICKS = 1780;
	localparam int BURST_TICKS  = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic calm;
	int   outstanding;
	int   mismatches;

	awt_chan_if #(.payload_t(awt_req_t)) req_if ();
	awt_chan_if #(.payload_t(awt_rsp_t)) rsp_if ();
	awt_chan_if #(.payload_t(awt_cfg_t)) cfg_if ();

	activation_window_throttle_policy uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	awt_policy_checker #(
		.NUM_CORES  (NUM_CORES),
		.COUNT_BITS (COUNT_BITS_DEF)
	) policy_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_if.valid),
		.req_ready   (req_if.ready),
		.req_data    (req_if.data),
		.rsp_valid   (rsp_if.valid),
		.rsp_ready   (rsp_if.ready),
		.rsp_data    (rsp_if.data),
		.cfg_valid   (cfg_if.valid),
		.cfg_ready   (cfg_if.ready),
		.cfg_data    (cfg_if.data),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#4000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : receiver
		int roll;
		int stall;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			roll = $urandom_range(0, 99);
			if (!arst_n || calm || roll < 70) begin
				rsp_if.ready <= arst_n;
			end else begin
				rsp_if.ready <= 1'b0;
				stall = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
				repeat (stall) @(posedge clk);
			end
		end
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 65) begin
			return 0;
		end
		if (roll < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic awt_req_t mk_tick(input logic rv, input logic ra, input logic [7:0] src);
		awt_req_t t;
		t.request_valid = rv;
		t.is_row_activation = ra;
		t.source_core = src;
		return t;
	endfunction

	function automatic awt_req_t random_tick(input int hot);
		int roll;
		logic [7:0] src;
		roll = $urandom_range(0, 19);
		if (roll < 9) begin
			src = 8'(hot);
		end else if (roll < 18) begin
			src = 8'($urandom_range(0, NUM_CORES - 1));
		end else begin
			src = 8'($urandom_range(NUM_CORES, 255));
		end
		return mk_tick($urandom_range(0, 7) != 0, $urandom_range(0, 5) != 0, src);
	endfunction

	task automatic send_tick(input awt_req_t t);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= t;
		do @(posedge clk); while (!req_if.ready);
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
		awt_cfg_t w;
		w.index = idx;
		w.value = value;
		cfg_if.valid <= 1'b1;
		cfg_if.data <= w;
		do @(posedge clk); while (!cfg_if.ready);
	endtask

	task automatic load_policy(
		input logic         en,
		input logic [30:0]  win,
		input logic [7:0]   qmin,
		input logic [7:0]   qmax,
		input logic [2:0]   cond,
		input logic [15:0]  thr,
		input action_kind_t kind,
		input logic [7:0]   amt
	);
		drain();
		write_reg(REG_ENABLED, 32'(en));
		write_reg(REG_WINDOW_CLOCKS, 32'(win));
		write_reg(REG_QUOTA_MIN, 32'(qmin));
		write_reg(REG_QUOTA_MAX, 32'(qmax));
		write_reg(REG_RULE_CONDITION, 32'(cond));
		write_reg(REG_RULE_THRESHOLD, 32'(thr));
		write_reg(REG_ACTION_KIND, 32'(kind));
		write_reg(REG_ACTION_AMOUNT, 32'(amt));
		cfg_if.valid <= 1'b0;
	endtask

	initial begin : stimulus
		int           sent;
		int           len;
		int           hot;
		logic         en;
		logic [30:0]  win;
		logic [7:0]   qmin;
		logic [7:0]   qmax;
		logic [15:0]  thr;
		logic [7:0]   amt;
		req_if.valid <= 1'b0;
		req_if.data <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.data <= '0;
		calm <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// disabled after reset: nothing counted or flagged
		send_tick(mk_tick(1'b1, 1'b1, 8'd0));
		send_tick(mk_tick(1'b1, 1'b1, 8'd255));
		send_tick(mk_tick(1'b0, 1'b0, 8'd3));

		// zero window length closes every tick
		load_policy(1'b1, 31'd0, 8'd1, 8'd128, {1'b0, OP_GE}, 16'd0, ACT_SET, 8'd128);
		send_tick(mk_tick(1'b1, 1'b1, 8'd7));
		send_tick(mk_tick(1'b1, 1'b1, 8'd8));
		send_tick(mk_tick(1'b1, 1'b0, 8'd3));
		send_tick(mk_tick(1'b0, 1'b1, 8'd3));
		send_tick(mk_tick(1'b1, 1'b1, 8'd255));

		// decrease clamped at the floor, repeat hit on a throttled core
		load_policy(1'b1, 31'd4, 8'd10, 8'd20, {1'b0, OP_GT}, 16'd1, ACT_DECREASE, 8'd128);
		repeat (4) send_tick(mk_tick(1'b1, 1'b1, 8'd1));

		// inverted quota bounds on the previous window count
		load_policy(1'b1, 31'd3, 8'd100, 8'd50, {1'b1, OP_LE}, 16'd0, ACT_SET, 8'd0);
		send_tick(mk_tick(1'b1, 1'b1, 8'd2));
		send_tick(mk_tick(1'b1, 1'b1, 8'd5));
		send_tick(mk_tick(1'b1, 1'b1, 8'd2));

		// new quota above 255 saturates
		load_policy(1'b1, 31'd5, 8'd1, 8'd255, {1'b1, OP_LT}, 16'hFFFF, ACT_DECREASE, 8'd0);
		repeat (2) send_tick(mk_tick(1'b1, 1'b1, 8'd6));

		// shrink the window mid-way, disabled close keeps throttled cores
		load_policy(1'b1, 31'd1000, 8'd1, 8'd128, {1'b0, OP_LE}, 16'd5, ACT_DECREASE, 8'd1);
		repeat (3) send_tick(mk_tick(1'b1, 1'b1, 8'd4));
		load_policy(1'b0, 31'd2, 8'd1, 8'd128, {1'b0, OP_LE}, 16'd5, ACT_DECREASE, 8'd1);
		send_tick(mk_tick(1'b1, 1'b1, 8'd4));
		send_tick(mk_tick(1'b1, 1'b1, 8'd9));
		load_policy(1'b1, 31'd2, 8'd1, 8'd128, {1'b0, OP_LE}, 16'd5, ACT_DECREASE, 8'd1);
		repeat (2) send_tick(mk_tick(1'b1, 1'b1, 8'd4));

		// drive one core for a burst in a long window, then read it back as previous
		load_policy(1'b1, 31'd70000, 8'd1, 8'd128, {1'b0, OP_GE}, 16'hFFFF, ACT_SET, 8'd64);
		calm <= 1'b1;
		repeat (BURST_TICKS) send_tick(mk_tick(1'b1, 1'b1, 8'd0));
		calm <= 1'b0;
		load_policy(1'b1, 31'h7FFF_FFFF, 8'd1, 8'd128, {1'b1, OP_LT}, 16'hFFFF, ACT_DECREASE, 8'd3);
		send_tick(mk_tick(1'b1, 1'b1, 8'd0));
		load_policy(1'b1, 31'd1, 8'd1, 8'd128, {1'b1, OP_LT}, 16'hFFFF, ACT_DECREASE, 8'd3);
		repeat (3) send_tick(mk_tick(1'b1, 1'b1, 8'd0));

		sent = 0;
		while (sent < RANDOM_TICKS) begin
			en = ($urandom_range(0, 4) != 0);
			case ($urandom_range(0, 9))
				0:       win = 31'h7FFF_FFFF;
				1:       win = 31'd0;
				2:       win = 31'($urandom_range(200, 5000));
				default: win = 31'($urandom_range(1, 40));
			endcase
			case ($urandom_range(0, 5))
				0:       qmin = 8'd1;
				1:       qmin = 8'd128;
				default: qmin = 8'($urandom_range(1, 128));
			endcase
			case ($urandom_range(0, 7))
				0:       qmax = 8'd255;
				1:       qmax = 8'd1;
				2:       qmax = 8'd128;
				default: qmax = 8'($urandom_range(1, 128));
			endcase
			case ($urandom_range(0, 9))
				0:       thr = 16'hFFFF;
				1:       thr = 16'd0;
				2:       thr = 16'($urandom_range(0, 65535));
				default: thr = 16'($urandom_range(0, 12));
			endcase
			case ($urandom_range(0, 5))
				0:       amt = 8'd0;
				1:       amt = 8'd128;
				default: amt = 8'($urandom_range(0, 128));
			endcase
			load_policy(en, win, qmin, qmax, 3'($urandom_range(0, 7)), thr,
				action_kind_t'($urandom_range(0, 1)), amt);
			calm <= ($urandom_range(0, 4) == 0);
			hot = $urandom_range(0, NUM_CORES - 1);
			len = $urandom_range(30, 150);
			repeat (len) begin
				if ($urandom_range(0, 199) == 0) begin
					drain();
				end
				send_tick(random_tick(hot));
			end
			sent += len;
		end

		drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
